@@ rtl/core/pdc_pkg.sv @@
`default_nettype none

package pdc_pkg;

    // Field widths
    localparam int DATA_WIDTH_DEF = 16;
    localparam int DT_WIDTH       = 16;
    localparam int CFG_IDX_WIDTH  = 2;

    // Q8.8 scaling: fraction bits of gains, errors and output
    localparam int FRAC_BITS = 8;

    // D term magnitude saturates at 2^48
    localparam int SAT_SHIFT = 48;

    // dt codes at or below this drop the D term (0.0001 s)
    localparam int DT_MIN_CODE = 6;

    // out_max reset value, truncated to the limit width
    localparam int OUT_MAX_RESET = 32767;

    // Register map
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_KP      = 2'd0,
        REG_KD      = 2'd1,
        REG_OUT_MAX = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/core/pdc_if.sv @@
`default_nettype none

// Sample channel: one control error and period per transfer
interface pdc_sample_if #(parameter int DATA_WIDTH = pdc_pkg::DATA_WIDTH_DEF);
    import pdc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [DATA_WIDTH-1:0] err;
    logic [DT_WIDTH-1:0]   dt;

    modport source (output valid, mode, err, dt, input ready);
    modport sink   (input valid, mode, err, dt, output ready);
endinterface

// Result channel: one clamped drive value per transfer
interface pdc_result_if #(parameter int DATA_WIDTH = pdc_pkg::DATA_WIDTH_DEF);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

// Configuration write channel
interface pdc_cfg_if #(parameter int DATA_WIDTH = pdc_pkg::DATA_WIDTH_DEF);
    import pdc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [DATA_WIDTH-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pdc_mul.sv @@
`default_nettype none

// Serial shift-add multiplier, one multiplier bit per cycle, LSB first.
module pdc_mul #(
    parameter int N = pdc_pkg::DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N-1:0]   a,
    input  logic [N-1:0]   b,
    output logic [2*N-1:0] prod,
    output logic           done
);
    import pdc_pkg::*;

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]   a_reg;
    logic [2*N-1:0] prod_reg;
    logic [2*N-1:0] prod_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           busy_reg;
    logic           busy_next;
    logic           done_reg;
    logic           done_next;
    logic [N:0]     upper_sum;

    // upper half accumulates a when the current multiplier bit is set
    assign upper_sum = {1'b0, prod_reg[2*N-1:N]} + (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        if (start)
        begin
            cnt_next  = CW'(N);
            busy_next = 1'b1;
            prod_next = {{N{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_next = {upper_sum, prod_reg[N-1:1]};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (start)
        begin
            a_reg <= a;
        end
    end

    assign prod = prod_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/pdc_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Quotient = floor((dividend << FRAC) / divisor); divisor must be nonzero.
module pdc_div #(
    parameter int NW   = 2 * pdc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC = pdc_pkg::FRAC_BITS,
    parameter int DW   = pdc_pkg::DT_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NW-1:0]      dividend,
    input  logic [DW-1:0]      divisor,
    output logic [NW+FRAC-1:0] quo,
    output logic               done
);
    import pdc_pkg::*;

    localparam int QW = NW + FRAC;
    localparam int CW = $clog2(QW + 1);

    // x_reg shifts dividend bits out the top and quotient bits in the bottom
    logic [QW-1:0] x_reg;
    logic [QW-1:0] x_next;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          fits;

    assign shifted = {rem_reg, x_reg[QW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !diff[DW+1];

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
            x_next    = {dividend, {FRAC{1'b0}}};
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            x_next   = {x_reg[QW-2:0], fits};
            rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quo  = x_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/pd_controller_clamped.sv @@
// Steps per sample: the two serial multipliers run together, then the serial divider
//   when dt > 6, then sum and clamp; a reset-mode sample goes straight to sum and clamp.
// One sample in flight: the next transfers only after the clamp step has handed its
//   result to the output register, which can wait on a stalled result channel.
// Reset (rst_n low, async): last error 0, kp and kd 0, out_max 32767 cut to its width (all
//   ones at 16 bits), no result pending, sample channel ready.
`default_nettype none

module pd_controller_clamped #(
    parameter int DATA_WIDTH = pdc_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    pdc_sample_if.sink    sample,
    pdc_result_if.source  result,
    pdc_cfg_if.sink       cfg
);
    import pdc_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int OW = W - 1;               // out_max width
    localparam int PW = 2 * W;               // product width
    localparam int QW = PW + FRAC_BITS;      // quotient width
    localparam int SW = QW + 2;              // signed sum width, holds both terms exactly
    localparam logic CAP_ON = (QW > SAT_SHIFT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_CLAMP
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [W-1:0]  kp_reg;
    logic [W-1:0]  kd_reg;
    logic [OW-1:0] out_max_reg;

    // Controller state
    logic [W-1:0]  last_err_reg;

    // Per-sample working registers
    logic [W-1:0]         err_reg;
    logic [W:0]           d_reg;       // err - last_error, exact in W+1 bits
    logic [DT_WIDTH-1:0]  dt_reg;
    logic                 d_en_reg;    // D term present (dt above threshold)
    logic                 clr_reg;     // reset-mode sample
    logic                 p_neg_reg;
    logic                 d_neg_reg;
    logic signed [SW-1:0] pterm_reg;
    logic signed [SW-1:0] dterm_reg;
    logic signed [SW-1:0] sum_reg;

    // Output register
    logic          out_valid_reg;
    logic [W-1:0]  drive_reg;

    logic          accept;
    logic          out_free;
    logic          load_out;
    logic          mul_start;
    logic          div_start;
    logic          mul_p_done;
    logic          mul_d_done;
    logic          mul_done;
    logic          div_done;
    logic [W:0]    d_diff;
    logic [W-1:0]  kp_mag;
    logic [W-1:0]  kd_mag;
    logic [W-1:0]  err_mag;
    logic [W:0]    d_mag;
    logic [PW-1:0] prod_p;
    logic [PW-1:0] prod_d;
    logic [QW-1:0] quo;
    logic [QW-1:0] cap_val;
    logic [QW-1:0] quo_cap;
    logic signed [SW-1:0] pmag_ext;
    logic signed [SW-1:0] dmag_ext;
    logic signed [SW-1:0] pterm_val;
    logic signed [SW-1:0] dterm_val;
    logic signed [SW-1:0] lim_pos;
    logic signed [SW-1:0] lim_neg;
    logic signed [SW-1:0] clamped;

    // Handshakes: one sample in flight; the output register lets the next
    // sample transfer while a finished result still waits.
    assign accept       = sample.valid && (state_reg == ST_IDLE);
    assign sample.ready = (state_reg == ST_IDLE);
    assign out_free     = !out_valid_reg || result.ready;
    assign load_out     = (state_reg == ST_CLAMP) && out_free;
    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;
    assign cfg.ready    = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= '0;
            kd_reg      <= '0;
            out_max_reg <= OW'(OUT_MAX_RESET);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KP:      kp_reg      <= cfg.data;
                REG_KD:      kd_reg      <= cfg.data;
                REG_OUT_MAX: out_max_reg <= cfg.data[OW-1:0];
                default:     ;
            endcase
        end
    end

    // Error difference against the stored error, exact in W+1 bits
    assign d_diff = {sample.err[W-1], sample.err} - {last_err_reg[W-1], last_err_reg};

    // Magnitudes for the unsigned serial multipliers
    assign kp_mag  = kp_reg[W-1]  ? (~kp_reg  + W'(1)) : kp_reg;
    assign kd_mag  = kd_reg[W-1]  ? (~kd_reg  + W'(1)) : kd_reg;
    assign err_mag = err_reg[W-1] ? (~err_reg + W'(1)) : err_reg;
    assign d_mag   = d_reg[W]     ? (~d_reg   + (W+1)'(1)) : d_reg;   // < 2^W

    assign mul_start = (state_reg == ST_START);
    assign mul_done  = mul_p_done && mul_d_done;
    assign div_start = (state_reg == ST_MUL) && mul_done && d_en_reg;

    // |kp| * |err|
    pdc_mul #(
        .N (W)
    ) u_mul_p (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (kp_mag),
        .b     (err_mag),
        .prod  (prod_p),
        .done  (mul_p_done)
    );

    // |kd| * |err - last_error|
    pdc_mul #(
        .N (W)
    ) u_mul_d (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (kd_mag),
        .b     (d_mag[W-1:0]),
        .prod  (prod_d),
        .done  (mul_d_done)
    );

    // floor(|kd*d| * 256 / dt)
    pdc_div #(
        .NW   (PW),
        .FRAC (FRAC_BITS),
        .DW   (DT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_d),
        .divisor  (dt_reg),
        .quo      (quo),
        .done     (div_done)
    );

    // P term: truncate toward zero by dropping fraction bits of the magnitude
    assign pmag_ext  = {{(SW - PW + FRAC_BITS){1'b0}}, prod_p[PW-1:FRAC_BITS]};
    assign pterm_val = p_neg_reg ? -pmag_ext : pmag_ext;

    // D term: magnitude saturates at 2^48 (only reachable at wide data)
    assign cap_val   = QW'(1) << SAT_SHIFT;
    assign quo_cap   = (CAP_ON && (quo >= cap_val)) ? cap_val : quo;
    assign dmag_ext  = {2'b00, quo_cap};
    assign dterm_val = d_neg_reg ? -dmag_ext : dmag_ext;

    // Symmetric clamp
    assign lim_pos = {{(SW - OW){1'b0}}, out_max_reg};
    assign lim_neg = -lim_pos;

    always_comb
    begin
        priority if (sum_reg > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (sum_reg < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = sum_reg;
        end
    end

    // Sequencer, stored error and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_err_reg  <= '0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
        end
        else
        begin
            // a new result replaces the one leaving in the same cycle
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                drive_reg     <= clamped[W-1:0];
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        // reset mode clears the stored error, else it takes this sample
                        last_err_reg <= sample.mode ? '0 : sample.err;
                        state_reg    <= sample.mode ? ST_SUM : ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= d_en_reg ? ST_DIV : ST_SUM;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP:
                begin
                    // hold the finished result until the output register frees up
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working registers, loaded by sequencer step
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg  <= sample.err;
            d_reg    <= d_diff;
            dt_reg   <= sample.dt;
            clr_reg  <= sample.mode;
            d_en_reg <= (sample.dt > DT_WIDTH'(DT_MIN_CODE));
        end
        if (state_reg == ST_START)
        begin
            p_neg_reg <= kp_reg[W-1] ^ err_reg[W-1];
            d_neg_reg <= kd_reg[W-1] ^ d_reg[W];
        end
        if ((state_reg == ST_MUL) && mul_done)
        begin
            pterm_reg <= pterm_val;
            dterm_reg <= '0;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            dterm_reg <= dterm_val;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= clr_reg ? '0 : (pterm_reg + dterm_reg);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pdc_checker.sv @@
`default_nettype none

module pdc_checker #(
    parameter int DATA_WIDTH = pdc_pkg::DATA_WIDTH_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [DATA_WIDTH-1:0]             drive,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [pdc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input wire logic [DATA_WIDTH-1:0]             cfg_data
);
    import pdc_pkg::*;

    localparam int OW = DATA_WIDTH - 1;

    logic [OW-1:0] lim_reg;
    logic [1:0]    outst_reg;
    logic          in_xfer;
    logic          out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Shadow of the limit register and count of samples not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg   <= OW'(OUT_MAX_RESET);
            outst_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && (cfg_index == REG_OUT_MAX))
            begin
                lim_reg <= cfg_data[OW-1:0];
            end
            outst_reg <= outst_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive))
        else $error("result changed while stalled");

    // Every result lies within the programmed limit
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(drive) <= $signed({1'b0, lim_reg}))
                   && ($signed(drive) >= -$signed({1'b0, lim_reg})))
        else $error("drive outside limit");

    // No result without a sample behind it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outst_reg != 2'd0))
        else $error("result without pending sample");

    // One sample in work plus one waiting result at most
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (outst_reg == 2'd2) |-> !in_ready)
        else $error("sample taken while full");

endmodule

bind pd_controller_clamped pdc_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .drive     (result.drive),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data)
);

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import pdc_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;

    // Sample modes
    localparam bit MODE_RUN   = 1'b0;
    localparam bit MODE_CLEAR = 1'b1;

    // Index outside the register map; the block must drop such writes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 2'd3;

    // Settle time at the end, longer than the worst-case result latency
    localparam int SETTLE_CYCLES = 3 * DW + 22;

    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 100;

    typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    // One line of the directed table: a sample transfer or a register write
    typedef struct {
        row_kind_t                kind;
        bit                       mode;
        logic signed [DW-1:0]     err;
        logic [DT_WIDTH-1:0]      dt;
        bit                       known;   // drive value typed in below
        logic signed [DW-1:0]     want;
        logic [CFG_IDX_WIDTH-1:0] index;
        logic [DW-1:0]            data;
    } plan_row_t;

    // One pending drive value, tagged with the sample that caused it
    typedef struct {
        logic signed [DW-1:0] drive;
        int                   tag;
    } drive_exp_t;

    logic clk = 1'b0;
    logic rst_n;

    pdc_sample_if #(.DATA_WIDTH(DW)) sample_ch ();
    pdc_result_if #(.DATA_WIDTH(DW)) result_ch ();
    pdc_cfg_if    #(.DATA_WIDTH(DW)) cfg_ch ();

    pd_controller_clamped #(.DATA_WIDTH(DW)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #1 clk = ~clk;

    // Controller image kept by the testbench: gains, limit and previous error
    logic signed [DW-1:0] gain_p;
    logic signed [DW-1:0] gain_d;
    logic [DW-2:0]        drive_limit;
    logic signed [DW-1:0] prev_err;

    drive_exp_t drive_fifo[$];
    plan_row_t  plan[$];

    bit quiet;          // no gaps on either side while set
    int fail_count;
    int n_samples;
    int n_clears;
    int n_writes;
    int n_checked;

    // Drive value for one sample; updates the stored previous error
    function automatic logic signed [DW-1:0] pd_drive(bit m, logic signed [DW-1:0] e,
                                                       logic [DT_WIDTH-1:0] t);
        longint          p_term;
        longint          d_term;
        longint          total;
        longint          lim;
        longint          diff;
        longint unsigned mag_k;
        longint unsigned mag_d;
        longint unsigned quo;
        bit              neg;
        if (m == MODE_CLEAR)
        begin
            prev_err = '0;
            return '0;
        end
        // P term: Q8.8 product scaled back, truncated toward zero
        p_term = (longint'(gain_p) * longint'(e)) / 256;
        d_term = 0;
        // tiny period: no D term, so no division by zero
        if (t > DT_MIN_CODE)
        begin
            diff  = longint'(e) - longint'(prev_err);
            mag_k = (gain_d < 0) ? longint'(-longint'(gain_d)) : longint'(gain_d);
            mag_d = (diff < 0) ? -diff : diff;
            neg   = (gain_d < 0) != (diff < 0);
            // product is below 2^32 at this width, so the scaled quotient never overflows
            quo    = (mag_k * mag_d * 256) / t;
            d_term = neg ? -longint'(quo) : longint'(quo);
        end
        prev_err = e;
        total = p_term + d_term;
        lim   = longint'(drive_limit);
        if (total > lim)
            total = lim;
        if (total < -lim)
            total = -lim;
        return total[DW-1:0];
    endfunction

    function automatic plan_row_t smp(bit m, int e, int t);
        plan_row_t r;
        r       = '{kind: ROW_SAMPLE, default: '0};
        r.mode  = m;
        r.err   = e[DW-1:0];
        r.dt    = t[DT_WIDTH-1:0];
        return r;
    endfunction

    function automatic plan_row_t fixed(bit m, int e, int t, int want);
        plan_row_t r;
        r       = smp(m, e, t);
        r.known = 1'b1;
        r.want  = want[DW-1:0];
        return r;
    endfunction

    function automatic plan_row_t wr(logic [CFG_IDX_WIDTH-1:0] idx, int val);
        plan_row_t r;
        r       = '{kind: ROW_WRITE, default: '0};
        r.index = idx;
        r.data  = val[DW-1:0];
        return r;
    endfunction

    function automatic logic [DW-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return '0;
            3, 4:    return 16'(int'($urandom_range(0, 2047)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'h7fff;
            2, 3:    return 16'($urandom_range(0, 2000));
            default: return 16'($urandom_range(0, 32767));
        endcase
    endfunction

    // Mostly full-range errors, with extremes and small steps from the last one
    function automatic logic [DW-1:0] pick_err();
        int v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            1, 2:
            begin
                v = int'(prev_err) + int'($urandom_range(0, 512)) - 256;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
            end
            default: v = $urandom;
        endcase
        return v[DW-1:0];
    endfunction

    function automatic logic [DT_WIDTH-1:0] pick_dt();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, DT_MIN_CODE));
            1:       return 16'(DT_MIN_CODE + 1);
            2:       return 16'hffff;
            3, 4:    return 16'($urandom_range(DT_MIN_CODE + 1, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_fail(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // One sample transfer; entered and left just after a falling edge
    task automatic push_sample(bit m, logic signed [DW-1:0] e, logic [DT_WIDTH-1:0] t,
                               bit known, logic signed [DW-1:0] want);
        int unsigned          gap;
        logic signed [DW-1:0] predicted;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.mode  <= m;
        sample_ch.err   <= e;
        sample_ch.dt    <= t;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        predicted = pd_drive(m, e, t);
        drive_fifo.push_back('{drive: known ? want : predicted, tag: n_samples});
        n_samples++;
        if (m == MODE_CLEAR)
            n_clears++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every drive value has come back
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (drive_fifo.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Register write; only called with the block idle
    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [DW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_KP:      gain_p = val;
            REG_KD:      gain_d = val;
            REG_OUT_MAX: drive_limit = val[DW-2:0];
            default:     ;   // unmapped index: write dropped
        endcase
        n_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Every input known from time zero
    initial
    begin
        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.mode   = MODE_RUN;
        sample_ch.err    = '0;
        sample_ch.dt     = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_KP;
        cfg_ch.data      = '0;
        result_ch.ready  = 1'b0;
    end

    // Result side: random stall before each transfer, then check against the oldest entry
    initial
    begin : result_sink
        int unsigned stall;
        drive_exp_t  head;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            if (drive_fifo.size() == 0)
            begin
                report_fail($sformatf("drive %0d arrived with nothing pending",
                                      $signed(result_ch.drive)));
            end
            else
            begin
                head = drive_fifo.pop_front();
                n_checked++;
                if (result_ch.drive !== head.drive)
                    report_fail($sformatf("sample %0d: drive expected %0d, got %0d",
                                          head.tag, head.drive, $signed(result_ch.drive)));
            end
            @(negedge clk);
        end
    end

    initial
    begin
        #1_000_000;
        $display("timeout with %0d drive values pending", drive_fifo.size());
        $display("FAIL pd_controller_clamped");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t  row;
        drive_exp_t lost;

        // register image after reset
        gain_p      = '0;
        gain_d      = '0;
        drive_limit = OUT_MAX_RESET[DW-2:0];
        prev_err    = '0;
        quiet       = 1'b0;

        // Directed table. Zero gains after reset give zero drive whatever the error.
        plan.push_back(fixed(MODE_RUN, 32767, 65535, 0));
        plan.push_back(fixed(MODE_RUN, -32768, 0, 0));
        plan.push_back(fixed(MODE_CLEAR, 16'h1234, 100, 0));
        // full P gain against the reset limit, both signs clamp
        plan.push_back(wr(REG_KP, 32767));
        plan.push_back(smp(MODE_RUN, 32767, 3));
        plan.push_back(smp(MODE_RUN, -32768, 3));
        // unity gains: D term dropped at the period threshold and at zero period
        plan.push_back(wr(REG_KP, 256));
        plan.push_back(wr(REG_KD, 256));
        plan.push_back(smp(MODE_RUN, 100, DT_MIN_CODE));
        plan.push_back(smp(MODE_RUN, 200, 0));
        plan.push_back(smp(MODE_RUN, 300, DT_MIN_CODE + 1));
        plan.push_back(smp(MODE_RUN, -32768, 65535));
        plan.push_back(smp(MODE_RUN, 32767, DT_MIN_CODE + 1));   // widest error step
        plan.push_back(fixed(MODE_CLEAR, -5, 1000, 0));
        plan.push_back(smp(MODE_RUN, 1, 65535));                 // step from a cleared error
        // most negative gains, largest intermediates
        plan.push_back(wr(REG_KP, -32768));
        plan.push_back(wr(REG_KD, -32768));
        plan.push_back(smp(MODE_RUN, -32768, DT_MIN_CODE + 1));
        plan.push_back(smp(MODE_RUN, 32767, DT_MIN_CODE + 1));
        plan.push_back(smp(MODE_RUN, 0, 65535));
        // zero limit pins drive at zero
        plan.push_back(wr(REG_OUT_MAX, 0));
        plan.push_back(fixed(MODE_RUN, 12345, 500, 0));
        plan.push_back(fixed(MODE_RUN, -32768, DT_MIN_CODE + 1, 0));
        // unmapped index must leave the registers alone
        plan.push_back(wr(REG_SPARE, 16'hffff));
        plan.push_back(wr(REG_OUT_MAX, 1000));
        plan.push_back(wr(REG_KP, 32767));
        plan.push_back(wr(REG_KD, 1));
        plan.push_back(smp(MODE_RUN, 500, 200));
        plan.push_back(smp(MODE_RUN, -500, 9));
        plan.push_back(smp(MODE_RUN, 32767, 65535));
        plan.push_back(fixed(MODE_CLEAR, 32767, 0, 0));

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_WRITE)
            begin
                drain();
                write_reg(row.index, row.data);
            end
            else
            begin
                push_sample(row.mode, row.err, row.dt, row.known, row.want);
            end
        end

        // Random phases: fresh gains and limit each time, some phases without gaps
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            quiet = (ph == 2 || ph == 5);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_SPARE, 16'($urandom));
            write_reg(REG_KP, pick_gain());
            write_reg(REG_KD, pick_gain());
            write_reg(REG_OUT_MAX, pick_limit());
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                push_sample(($urandom_range(0, 9) == 0) ? MODE_CLEAR : MODE_RUN,
                            pick_err(), pick_dt(), 1'b0, '0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (drive_fifo.size() != 0)
        begin
            lost = drive_fifo.pop_front();
            report_fail($sformatf("sample %0d: drive %0d never arrived",
                                  lost.tag, lost.drive));
        end

        $display("Covered %0d samples (%0d clear-mode) over %0d register writes,",
                 n_samples, n_clears, n_writes);
        $display("%0d drive values checked, %0d failures", n_checked, fail_count);
        if (fail_count == 0)
            $display("PASS pd_controller_clamped");
        else
            $display("FAIL pd_controller_clamped");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pdc_pkg.sv
rtl/core/pdc_if.sv
rtl/core/pdc_mul.sv
rtl/core/pdc_div.sv
rtl/core/pd_controller_clamped.sv
rtl/core/pdc_checker.sv
test/tb_top.sv
